// ----- rtl/afr_pkg.sv -----
// ----------------------------------------------------------------------------
// afr_pkg - shared types and constants of the ASCII frame receiver/router
// Byte codes, link codes and the request that hands a closed frame to the
// result emitter.
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_ONE  = 8'h31;

  localparam logic [1:0] DEST_REPLY    = 2'd0;
  localparam logic [1:0] DEST_LINK_ONE = 2'd1;
  localparam logic [1:0] DEST_LINK_TWO = 2'd2;

  // Request from the frame assembler to the emitter on a closing byte
  typedef struct packed {
    logic       load;
    logic       routed;
    logic [1:0] link;
    logic [7:0] answer;
  } emit_req_t;

endpackage

// ----- rtl/afr_if.sv -----
// ----------------------------------------------------------------------------
// afr_if - handshake channels of the ASCII frame receiver/router
// Received byte channel and routed result channel, valid/ready.
// ----------------------------------------------------------------------------
interface afr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] dest;
  logic [7:0] data_byte;
  logic       last_of_run;

  modport source (output valid, output dest, output data_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input dest, input data_byte, input last_of_run,
                  output ready);
endinterface

// ----- rtl/ascii_frame_receiver_router.sv -----
// ----------------------------------------------------------------------------
// ascii_frame_receiver_router - ASCII command frame receiver and router
// Assembles start, two address bytes, payload and closing byte, then routes
// the payload to link one or two on request and answers on the reply link.
// ----------------------------------------------------------------------------
//  channel | modport | payload                       | per request
//  rx_i    | sink    | rx_byte[7:0]                  | one received byte
//  res_o   | source  | dest[1:0] data_byte[7:0] last | one byte for one link
//
//  Every byte is taken in the cycle it is offered; only the closing byte waits,
//  and only while the emitter still holds results of the previous frame.
//  A closing byte gives PAYLOAD_BYTES + 1 results (routed) or one result,
//  one per ready cycle from the result register and the payload shift line.
//  Results of one frame overlap with reception of the next.
//  Reset clears the frame position and the emitter; stored bytes need none.
//  A stall on res_o holds the current result and blocks only a closing byte.
module ascii_frame_receiver_router #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  afr_rx_if.sink    rx_i,
  afr_res_if.source res_o
);
  import afr_pkg::*;

  localparam int PosW     = $clog2(PAYLOAD_BYTES + 4);
  localparam int ClosePos = PAYLOAD_BYTES + 3;

  logic [PosW-1:0]               pos_q, pos_d;
  logic                          addr0_one_q, addr0_one_d;
  logic                          addr1_one_q, addr1_one_d;
  logic [PAYLOAD_BYTES-1:0][7:0] pay_q, pay_d;
  logic                          at_close;
  logic                          can_load;
  logic                          accept;
  emit_req_t                     req;

  assign at_close   = (pos_q == PosW'(ClosePos));
  assign rx_i.ready = !at_close || can_load;
  assign accept     = rx_i.valid && rx_i.ready;

  always_comb begin
    pos_d       = pos_q;
    addr0_one_d = addr0_one_q;
    addr1_one_d = addr1_one_q;
    pay_d       = pay_q;
    if (accept) begin
      priority if (pos_q == '0) begin
        // drop everything but the start byte
        if (rx_i.rx_byte == ASCII_ZERO) pos_d = PosW'(1);
      end else if (pos_q == PosW'(1)) begin
        addr0_one_d = (rx_i.rx_byte == ASCII_ONE);
        pos_d       = PosW'(2);
      end else if (pos_q == PosW'(2)) begin
        addr1_one_d = (rx_i.rx_byte == ASCII_ONE);
        pos_d       = PosW'(3);
      end else if (!at_close) begin
        for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
          pay_d[i] = pay_q[i+1];
        end
        pay_d[PAYLOAD_BYTES-1] = rx_i.rx_byte;
        pos_d = pos_q + PosW'(1);
      end else begin
        pos_d = '0;
      end
    end
  end

  always_comb begin
    req.load   = accept && at_close;
    req.routed = (rx_i.rx_byte == ASCII_ONE) && !addr0_one_q;
    req.link   = addr1_one_q ? DEST_LINK_TWO : DEST_LINK_ONE;
    req.answer = (rx_i.rx_byte == ASCII_ONE) ? ASCII_ONE : ASCII_ZERO;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr0_one_q <= addr0_one_d;
    addr1_one_q <= addr1_one_d;
    pay_q       <= pay_d;
  end

  afr_emitter #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .payload_i (pay_q),
    .can_load_o(can_load),
    .res_o     (res_o)
  );

endmodule

// ----- rtl/afr_emitter.sv -----
// ----------------------------------------------------------------------------
// afr_emitter - result sequencer
// Holds the result register and a shift line of the remaining payload bytes,
// and emits one result, or PAYLOAD_BYTES + 1 when routed, per accepted request.
// ----------------------------------------------------------------------------
module afr_emitter #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  afr_pkg::emit_req_t               req_i,
  input  logic [PAYLOAD_BYTES-1:0][7:0]    payload_i,
  output logic                             can_load_o,
  afr_res_if.source                        res_o
);
  import afr_pkg::*;

  localparam int RemW = $clog2(PAYLOAD_BYTES + 1);

  logic                          out_valid_q, out_valid_d;
  logic [RemW-1:0]               rem_q, rem_d;
  logic [1:0]                    link_q, link_d;
  logic [1:0]                    dest_q, dest_d;
  logic [7:0]                    byte_q, byte_d;
  logic                          last_q, last_d;
  logic [PAYLOAD_BYTES-1:0][7:0] buf_q, buf_d;
  logic                          advance;

  assign advance    = out_valid_q && res_o.ready;
  // a new run may enter as the final result of the current one leaves
  assign can_load_o = !out_valid_q || (res_o.ready && (rem_q == '0));

  always_comb begin
    out_valid_d = out_valid_q;
    rem_d       = rem_q;
    link_d      = link_q;
    dest_d      = dest_q;
    byte_d      = byte_q;
    last_d      = last_q;
    buf_d       = buf_q;
    if (req_i.load) begin
      out_valid_d = 1'b1;
      link_d      = req_i.link;
      if (req_i.routed) begin
        dest_d = req_i.link;
        byte_d = payload_i[0];
        last_d = 1'b0;
        rem_d  = RemW'(PAYLOAD_BYTES);
        // load the rest of the payload, answer at the tail
        for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
          buf_d[i] = payload_i[i+1];
        end
        buf_d[PAYLOAD_BYTES-1] = ASCII_ONE;
      end else begin
        dest_d = DEST_REPLY;
        byte_d = req_i.answer;
        last_d = 1'b1;
        rem_d  = '0;
      end
    end else if (advance) begin
      if (rem_q != '0) begin
        byte_d = buf_q[0];
        dest_d = (rem_q == RemW'(1)) ? DEST_REPLY : link_q;
        last_d = (rem_q == RemW'(1));
        rem_d  = rem_q - RemW'(1);
        for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
          buf_d[i] = buf_q[i+1];
        end
        buf_d[PAYLOAD_BYTES-1] = ASCII_ONE;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    link_q <= link_d;
    dest_q <= dest_d;
    byte_q <= byte_d;
    last_q <= last_d;
    buf_q  <= buf_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.dest        = dest_q;
  assign res_o.data_byte   = byte_q;
  assign res_o.last_of_run = last_q;

endmodule

// ----- rtl/afr_checker.sv -----
// ----------------------------------------------------------------------------
// afr_checker - port-level checks of the ASCII frame receiver/router
// Watches the result channel for held requests and consistent routing.
// ----------------------------------------------------------------------------
module afr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_dest_i,
  input logic [7:0] out_data_i,
  input logic       out_last_i
);
  import afr_pkg::*;

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_dest_i) && $stable(out_data_i) && $stable(out_last_i))
    else $error("result payload changed while stalled");

  a_reply_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_dest_i == DEST_REPLY) |->
      out_last_i && ((out_data_i == ASCII_ZERO) || (out_data_i == ASCII_ONE)))
    else $error("reply link result is not a closing answer");

  a_payload_routed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |->
      (out_dest_i == DEST_LINK_ONE) || (out_dest_i == DEST_LINK_TWO))
    else $error("payload result not on an output link");

endmodule

bind ascii_frame_receiver_router afr_checker u_afr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .out_dest_i (res_o.dest),
  .out_data_i (res_o.data_byte),
  .out_last_i (res_o.last_of_run)
);
